// ----- src/vtge_pkg.sv -----
// Shared constants, types and helper functions for the vector tile geometry encoder.
`default_nettype none

package vtge_pkg;

	localparam int COORD_WIDTH    = 24;
	localparam int COORD_IN_WIDTH = 24;
	localparam int LEN_WIDTH      = 16;
	localparam int WORD_WIDTH     = 32;
	localparam int KIND_WIDTH     = 2;
	localparam int MAX_WORDS      = 3;
	localparam int IN_DATA_WIDTH  = 80;
	localparam int IN_USER_WIDTH  = 2;
	localparam int OUT_USER_WIDTH = 2;

	typedef logic [COORD_WIDTH-1:0] coord_t;
	typedef logic [WORD_WIDTH-1:0]  word_t;
	typedef logic [LEN_WIDTH-1:0]   len_t;
	typedef logic [1:0]             word_cnt_t;

	typedef enum logic [2:0] {
		CMD_MOVETO    = 3'd1,
		CMD_LINETO    = 3'd2,
		CMD_CLOSEPATH = 3'd7
	} cmd_id_t;

	typedef enum logic [KIND_WIDTH-1:0] {
		KIND_POINT   = 2'd0,
		KIND_LINE    = 2'd1,
		KIND_POLYGON = 2'd2,
		KIND_SPARE   = 2'd3
	} geom_kind_t;

	localparam len_t LEN_MAX       = {LEN_WIDTH{1'b1}};
	localparam len_t MIN_LINE_LEN  = len_t'(2);
	localparam len_t MIN_POLY_LEN  = len_t'(4);

	// Takes the low COORD_WIDTH bits of an input coordinate, sign-extending the
	// input when the internal width is larger than the port.
	function automatic coord_t to_coord(input logic [COORD_IN_WIDTH-1:0] v);
		coord_t r;
		for (int i = 0; i < COORD_WIDTH; i++) begin
			r[i] = (i < COORD_IN_WIDTH) ? v[i] : v[COORD_IN_WIDTH-1];
		end
		return r;
	endfunction

	function automatic word_t make_cmd(input cmd_id_t id, input len_t count);
		return {{(WORD_WIDTH-LEN_WIDTH-3){1'b0}}, count, id};
	endfunction

	// Zigzag code of cur - prev, taken over 32 bits.
	function automatic word_t zigzag_delta(input coord_t cur, input coord_t prev);
		logic signed [COORD_WIDTH:0] d;
		word_t dw;
		d  = $signed({cur[COORD_WIDTH-1], cur}) - $signed({prev[COORD_WIDTH-1], prev});
		dw = {{(WORD_WIDTH-COORD_WIDTH-1){d[COORD_WIDTH]}}, d};
		return {dw[WORD_WIDTH-2:0], 1'b0} ^ {WORD_WIDTH{dw[WORD_WIDTH-1]}};
	endfunction

endpackage

`default_nettype wire

// ----- src/vector_tile_geometry_encoder.sv -----
// Top level: point framing, command generation and word serializer of the tile encoder.
// The first word of an item is offered from the serializer register, which it enters from the input register.
// Words leave at one word per cycle while m_tready is high; an item gives zero to three words,
// and an item that yields no word still passes through the input register.
// The serializer register holds the words of one item while the next item waits in the
// input register. Asynchronous active-low reset clears the handshake state, the kind
// register, the previous point and the ring index.
`default_nettype none

module vector_tile_geometry_encoder (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration write channel: geometry_kind.
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [vtge_pkg::KIND_WIDTH-1:0]     cfg_data,
	// Point input.
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// coord_x [23:0], coord_y [47:24], ring_length [63:48], feature_point_total [79:64]
	input  wire logic [vtge_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
	// feature_start [0], ring_start [1]
	input  wire logic [vtge_pkg::IN_USER_WIDTH-1:0]  s_tuser,
	// feature_end
	input  wire logic                                s_tlast,
	// Geometry word output.
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// geometry_word [31:0]
	output logic [vtge_pkg::WORD_WIDTH-1:0]          m_tdata,
	// word_valid [0], last_of_item [1]
	output logic [vtge_pkg::OUT_USER_WIDTH-1:0]      m_tuser,
	// end_of_feature
	output logic                                     m_tlast
);
	import vtge_pkg::*;

	// Input register.
	logic                           valid_s1;
	logic [COORD_IN_WIDTH-1:0]      x_s1, y_s1;
	len_t                           rlen_s1, total_s1;
	logic                           fstart_s1, rstart_s1, fend_s1;

	// Serializer register.
	word_t                          words_s2 [MAX_WORDS];
	word_cnt_t                      cnt_s2;
	logic                           bare_s2, fend_s2;

	// Encoder state.
	geom_kind_t                     kind_q;
	coord_t                         prev_x_q, prev_y_q;
	len_t                           pir_q;

	logic                           s2_free, advance;

	// Combinational encode of the item in the input register.
	coord_t                         cur_x, cur_y, base_x, base_y;
	logic                           poly, ringed, has_cmd, emit_point;
	len_t                           j, drawn, min_len, j_next;
	word_t                          cmd_word, dx_word, dy_word;
	word_t                          nxt_words [MAX_WORDS];
	word_cnt_t                      nxt_cnt;
	logic                           nxt_bare;

	assign cfg_ready = 1'b1;

	assign s2_free  = (cnt_s2 == word_cnt_t'(0)) || ((cnt_s2 == word_cnt_t'(1)) && m_tready);
	assign advance  = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		cur_x   = to_coord(x_s1);
		cur_y   = to_coord(y_s1);
		base_x  = fstart_s1 ? '0 : prev_x_q;
		base_y  = fstart_s1 ? '0 : prev_y_q;
		poly    = kind_q[1];
		ringed  = (kind_q != KIND_POINT);
		j       = (fstart_s1 || rstart_s1) ? '0 : pir_q;
		min_len = poly ? MIN_POLY_LEN : MIN_LINE_LEN;
		drawn   = poly ? rlen_s1 - len_t'(1) : rlen_s1;
		j_next  = (j != LEN_MAX) ? j + len_t'(1) : LEN_MAX;

		has_cmd    = 1'b0;
		emit_point = 1'b0;
		cmd_word   = make_cmd(CMD_MOVETO, total_s1);
		if (!ringed) begin
			has_cmd    = fstart_s1;
			emit_point = 1'b1;
		end else if (rlen_s1 >= min_len) begin
			if (j < drawn) begin
				emit_point = 1'b1;
				if (j == len_t'(0)) begin
					has_cmd  = 1'b1;
					cmd_word = make_cmd(CMD_MOVETO, len_t'(1));
				end else if (j == len_t'(1)) begin
					has_cmd  = 1'b1;
					cmd_word = make_cmd(CMD_LINETO, drawn - len_t'(1));
				end
			end else if (poly && (j == drawn)) begin
				has_cmd  = 1'b1;
				cmd_word = make_cmd(CMD_CLOSEPATH, len_t'(1));
			end
		end

		dx_word = zigzag_delta(cur_x, base_x);
		dy_word = zigzag_delta(cur_y, base_y);

		nxt_bare     = 1'b0;
		nxt_words[0] = '0;
		nxt_words[1] = dy_word;
		nxt_words[2] = dy_word;
		if (has_cmd) begin
			nxt_words[0] = cmd_word;
			nxt_words[1] = dx_word;
			nxt_cnt      = emit_point ? word_cnt_t'(3) : word_cnt_t'(1);
		end else if (emit_point) begin
			nxt_words[0] = dx_word;
			nxt_cnt      = word_cnt_t'(2);
		end else begin
			// A feature end with nothing to draw still sends one marker transaction.
			nxt_bare = fend_s1;
			nxt_cnt  = fend_s1 ? word_cnt_t'(1) : word_cnt_t'(0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_s1      <= s_tdata[23:0];
			y_s1      <= s_tdata[47:24];
			rlen_s1   <= s_tdata[63:48];
			total_s1  <= s_tdata[79:64];
			fstart_s1 <= s_tuser[0];
			rstart_s1 <= s_tuser[1];
			fend_s1   <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (advance) begin
			cnt_s2 <= nxt_cnt;
		end else if (m_tvalid && m_tready) begin
			cnt_s2 <= cnt_s2 - word_cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			words_s2 <= nxt_words;
			bare_s2  <= nxt_bare;
			fend_s2  <= fend_s1;
		end else if (m_tvalid && m_tready) begin
			words_s2[0] <= words_s2[1];
			words_s2[1] <= words_s2[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_POINT;
			prev_x_q <= '0;
			prev_y_q <= '0;
			pir_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				kind_q <= geom_kind_t'(cfg_data);
			end
			if (advance) begin
				if (emit_point) begin
					prev_x_q <= cur_x;
					prev_y_q <= cur_y;
				end else begin
					prev_x_q <= base_x;
					prev_y_q <= base_y;
				end
				if (ringed) begin
					pir_q <= j_next;
				end
			end
		end
	end

	assign m_tvalid = (cnt_s2 != word_cnt_t'(0));
	assign m_tdata  = words_s2[0];
	assign m_tuser  = {cnt_s2 == word_cnt_t'(1), !bare_s2};
	assign m_tlast  = (cnt_s2 == word_cnt_t'(1)) && fend_s2;

endmodule

`default_nettype wire

// ----- src/vtge_checker.sv -----
// Port-level checker for the vector tile geometry encoder and its bind statement.
`default_nettype none

module vtge_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                cfg_valid,
	input wire logic                                cfg_ready,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [vtge_pkg::WORD_WIDTH-1:0]     m_tdata,
	input wire logic [vtge_pkg::OUT_USER_WIDTH-1:0] m_tuser,
	input wire logic                                m_tlast
);
	import vtge_pkg::*;

	// A stalled output transaction keeps its word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output transaction changed while stalled");

	// A bare feature-end marker is a single zero transaction that closes the feature.
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[1] && m_tlast && (m_tdata == '0))
		else $error("malformed bare end marker");

	// The end of a feature is always the last word of its point.
	a_tlast_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[1])
		else $error("feature end on a word that is not the last of its point");

	// Configuration is never back-pressured.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind vector_tile_geometry_encoder vtge_checker u_vtge_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.m_tlast   (m_tlast)
);

`default_nettype wire
